/* rtl/tlbpt_pkg.sv */
`timescale 1ns / 1ps

package tlbpt_pkg;

	localparam int ADDR_W      = 16;
	localparam int CNT_W       = 32;
	localparam int TLB_ENTRIES = 16;
	localparam int OFFSET_BITS = 8;
	localparam int PAGE_COUNT  = 256;
	localparam int FRAME_COUNT = 256;
	localparam int PAGE_W      = $clog2(PAGE_COUNT);
	localparam int FRAME_W     = $clog2(FRAME_COUNT);

	// controller -> datapath
	typedef struct packed {
		logic capture;  // item accepted: latch address, start page-table read
		logic commit;   // finish lookup, update state, load output register
	} tlbpt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_blocked;  // output register full and not drained this cycle
	} tlbpt_sts_t;

endpackage

/* rtl/tlbpt_ctrl.sv */
`timescale 1ns / 1ps

module tlbpt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tlbpt_pkg::tlbpt_sts_t sts,
	output tlbpt_pkg::tlbpt_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_LOOK = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOOK;
				end
			end
			ST_LOOK: begin
				// hold until the output register can take the result
				if (!sts.out_blocked) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/tlbpt_datapath.sv */
`timescale 1ns / 1ps

module tlbpt_datapath #(
	parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES,
	parameter int OFFSET_BITS = tlbpt_pkg::OFFSET_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tlbpt_pkg::tlbpt_cmd_t              cmd,
	output tlbpt_pkg::tlbpt_sts_t              sts,
	input  logic [tlbpt_pkg::ADDR_W-1:0]       virt_addr,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [tlbpt_pkg::ADDR_W-1:0]       physical_address,
	output logic                               tlb_hit,
	output logic                               page_fault,
	output logic [tlbpt_pkg::CNT_W-1:0]        translated_count,
	output logic [tlbpt_pkg::CNT_W-1:0]        fault_count,
	output logic [tlbpt_pkg::CNT_W-1:0]        hit_count
);

	localparam int AW    = tlbpt_pkg::ADDR_W;
	localparam int CW    = tlbpt_pkg::CNT_W;
	localparam int PW    = tlbpt_pkg::PAGE_W;
	localparam int FW    = tlbpt_pkg::FRAME_W;
	localparam int PAGES = tlbpt_pkg::PAGE_COUNT;
	localparam int TIW   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
	localparam logic [AW-1:0] OFF_MASK = AW'((64'd1 << OFFSET_BITS) - 64'd1);
	localparam logic [TIW-1:0] FILL_LAST = TIW'(TLB_ENTRIES - 1);
	localparam logic [FW-1:0] FRAME_LAST = FW'(tlbpt_pkg::FRAME_COUNT - 1);

	logic [AW-1:0]  addr_q;
	logic [PW-1:0]  tag_q [TLB_ENTRIES];
	logic [FW-1:0]  frm_q [TLB_ENTRIES];
	logic [TLB_ENTRIES-1:0] tv_q;
	logic [TIW-1:0] fill_q;
	logic [FW-1:0]  pt_mem [PAGES];
	logic [PAGES-1:0] pv_q;
	logic [FW-1:0]  pt_rd_q;
	logic [FW-1:0]  next_q;
	logic [CW-1:0]  trans_q;
	logic [CW-1:0]  faults_q;
	logic [CW-1:0]  hits_q;
	logic           out_valid_q;

	logic [AW-1:0]  in_shift;
	logic [PW-1:0]  in_page;
	logic [AW-1:0]  cur_shift;
	logic [PW-1:0]  cur_page;
	logic           hit;
	logic [FW-1:0]  hit_frm;
	logic           pv;
	logic           fault;
	logic [FW-1:0]  frame;
	logic [AW-1:0]  phys;

	// page number modulo the table size is its low bits
	assign in_shift  = virt_addr >> OFFSET_BITS;
	assign in_page   = in_shift[PW-1:0];
	assign cur_shift = addr_q >> OFFSET_BITS;
	assign cur_page  = cur_shift[PW-1:0];

	// reverse scan so the lowest matching entry wins
	always_comb begin
		hit     = 1'b0;
		hit_frm = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			if (tv_q[i] && (tag_q[i] == cur_page)) begin
				hit     = 1'b1;
				hit_frm = frm_q[i];
			end
		end
	end

	assign pv    = pv_q[cur_page];
	assign fault = !hit && !pv;
	assign frame = hit ? hit_frm : (pv ? pt_rd_q : next_q);
	assign phys  = (AW'(frame) << OFFSET_BITS) | (addr_q & OFF_MASK);

	assign sts.out_blocked = out_valid_q && !out_ready;
	assign out_valid       = out_valid_q;

	// page-table memory and payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q  <= virt_addr;
			pt_rd_q <= pt_mem[in_page];
		end
		if (cmd.commit && fault) begin
			pt_mem[cur_page] <= next_q;
		end
		if (cmd.commit && !hit) begin
			tag_q[fill_q] <= cur_page;
			frm_q[fill_q] <= frame;
		end
		if (cmd.commit) begin
			physical_address <= phys;
			tlb_hit          <= hit;
			page_fault       <= fault;
			translated_count <= trans_q + 1'b1;
			fault_count      <= fault ? faults_q + 1'b1 : faults_q;
			hit_count        <= hit ? hits_q + 1'b1 : hits_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tv_q        <= '0;
			fill_q      <= '0;
			pv_q        <= '0;
			next_q      <= '0;
			trans_q     <= '0;
			faults_q    <= '0;
			hits_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				trans_q     <= trans_q + 1'b1;
				if (hit) begin
					hits_q <= hits_q + 1'b1;
				end else begin
					tv_q[fill_q] <= 1'b1;
					fill_q       <= (fill_q == FILL_LAST) ? '0 : fill_q + 1'b1;
				end
				if (fault) begin
					faults_q       <= faults_q + 1'b1;
					pv_q[cur_page] <= 1'b1;
					next_q         <= (next_q == FRAME_LAST) ? '0 : next_q + 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/tlb_page_table_translate.sv */
`timescale 1ns / 1ps
// The accepting edge latches the address and reads the page-table memory; the lookup
// state then updates the TLB / page table and loads the output register, waiting while
// the output is blocked. A new item is accepted only once the previous one has committed.
// Reset (arst_n low, asynchronous): clears TLB and page valid bits, fill pointer,
// frame allocator, counters and output valid at once; no clearing pass.
module tlb_page_table_translate #(
	parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES,
	parameter int OFFSET_BITS = tlbpt_pkg::OFFSET_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tlbpt_pkg::ADDR_W-1:0] virt_addr,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tlbpt_pkg::ADDR_W-1:0] physical_address,
	output logic                         tlb_hit,
	output logic                         page_fault,
	output logic [tlbpt_pkg::CNT_W-1:0]  translated_count,
	output logic [tlbpt_pkg::CNT_W-1:0]  fault_count,
	output logic [tlbpt_pkg::CNT_W-1:0]  hit_count
);

	tlbpt_pkg::tlbpt_cmd_t cmd;
	tlbpt_pkg::tlbpt_sts_t sts;

	tlbpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tlbpt_datapath #(
		.TLB_ENTRIES (TLB_ENTRIES),
		.OFFSET_BITS (OFFSET_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.virt_addr        (virt_addr),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.physical_address (physical_address),
		.tlb_hit          (tlb_hit),
		.page_fault       (page_fault),
		.translated_count (translated_count),
		.fault_count      (fault_count),
		.hit_count        (hit_count)
	);

endmodule
